// ===== hdl/ppmd_pkg.sv =====
package ppmd_pkg;

    // number of radio channels held per frame
    localparam int CHANNELS = 8;
    localparam int IDX_W    = $clog2(CHANNELS);
    localparam int CNT_W    = $clog2(CHANNELS + 1);

    localparam int DATA_W   = 16;
    localparam int CH_W     = 3;
    localparam int VALUE_W  = 15;
    localparam int CFG_IDX_W = 2;

    localparam logic [DATA_W-1:0]  RAW_RESET  = 16'd2400;
    localparam logic [DATA_W-1:0]  NO_CHANGE  = 16'hFFFF;
    localparam logic [VALUE_W-1:0] VALUE_MAX  = 15'h7FFF;

    localparam logic [DATA_W-1:0] MIN_PULSE_RESET = 16'd900;
    localparam logic [DATA_W-1:0] MAX_PULSE_RESET = 16'd2100;
    localparam logic [DATA_W-1:0] SYNC_RESET      = 16'd8000;
    localparam logic [DATA_W-1:0] TIMER_TOP_RESET = 16'd40000;

    typedef enum logic [1:0] {
        KIND_CAPTURE = 2'd0,
        KIND_READ    = 2'd1,
        KIND_SET     = 2'd2,
        KIND_CLEAR   = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_PULSE = 2'd0,
        REG_MAX_PULSE = 2'd1,
        REG_SYNC      = 2'd2,
        REG_TIMER_TOP = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [DATA_W-1:0] min_pulse_us;
        logic [DATA_W-1:0] max_pulse_us;
        logic [DATA_W-1:0] sync_threshold;
        logic [DATA_W-1:0] timer_top;
    } cfg_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               clear_ready;
    } rd_res_t;

endpackage

// ===== hdl/ppmd_read_path.sv =====
module ppmd_read_path (
    input  ppmd_pkg::cfg_t                  cfg,
    input  logic [ppmd_pkg::DATA_W-1:0]     raw_width,
    input  logic [ppmd_pkg::DATA_W-1:0]     ovr_entry,
    output ppmd_pkg::rd_res_t               res
);

    logic [ppmd_pkg::DATA_W-1:0] half;
    logic [ppmd_pkg::DATA_W-1:0] clamped;

    assign half = {1'b0, raw_width[ppmd_pkg::DATA_W-1:1]};

    // when the bounds cross, widths below the lower bound take it and all others take the upper bound
    always_comb
    begin
        if (half < cfg.min_pulse_us)
        begin
            clamped = cfg.min_pulse_us;
        end
        else if (half > cfg.max_pulse_us)
        begin
            clamped = cfg.max_pulse_us;
        end
        else
        begin
            clamped = half;
        end
    end

    always_comb
    begin
        if (ovr_entry != '0)
        begin
            // negative override reads as zero
            res.value       = ovr_entry[ppmd_pkg::DATA_W-1] ? '0
                                : ovr_entry[ppmd_pkg::VALUE_W-1:0];
            res.clear_ready = 1'b0;
        end
        else
        begin
            res.value       = clamped[ppmd_pkg::DATA_W-1] ? ppmd_pkg::VALUE_MAX
                                : clamped[ppmd_pkg::VALUE_W-1:0];
            res.clear_ready = 1'b1;
        end
    end

endmodule

// ===== hdl/ppm_radio_channel_decoder_core.sv =====
// ppm radio channel decoder: takes capture timestamps, channel reads, override
// writes and override clears as input words and returns exactly one result word
// per input word. an accepted word sits in an input register while the capture,
// read and override logic works on it, then its result goes to the output
// register and is held there until the consumer takes it. one word is taken
// every clock while the output side takes results; the rate is set by that
// single stage between the input and result registers. while a finished
// result waits for the consumer the input register still takes one more
// word, after which in_ready drops until the result is taken. the
// configuration port writes one register per enabled edge (min/max pulse
// clamp, sync threshold or timer top, chosen by cfg_index), and should only
// be used while no word is in flight.
module ppm_radio_channel_decoder_core (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_we,
    input  logic [ppmd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ppmd_pkg::DATA_W-1:0]          cfg_data,

    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           kind,
    input  logic [ppmd_pkg::DATA_W-1:0]          capture_time,
    input  logic [ppmd_pkg::CH_W-1:0]            channel,
    input  logic signed [ppmd_pkg::DATA_W-1:0]   override_value,

    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [ppmd_pkg::VALUE_W-1:0]         channel_value,
    output logic                                 frame_ready,
    output logic                                 override_active
);

    // configuration registers
    ppmd_pkg::cfg_t cfg_reg;

    // input stage
    logic                             s1_valid_reg;
    ppmd_pkg::kind_t                  s1_kind_reg;
    logic [ppmd_pkg::DATA_W-1:0]      s1_cap_reg;
    logic [ppmd_pkg::CH_W-1:0]        s1_ch_reg;
    logic [ppmd_pkg::DATA_W-1:0]      s1_ov_reg;
    logic                             s1_fire;

    // decoder state
    logic [ppmd_pkg::DATA_W-1:0]      last_capture_reg, last_capture_next;
    logic [ppmd_pkg::CNT_W-1:0]       next_channel_reg, next_channel_next;
    logic [ppmd_pkg::DATA_W-1:0]      raw_reg  [ppmd_pkg::CHANNELS];
    logic [ppmd_pkg::DATA_W-1:0]      raw_next [ppmd_pkg::CHANNELS];
    logic [ppmd_pkg::DATA_W-1:0]      ovr_reg  [ppmd_pkg::CHANNELS];
    logic [ppmd_pkg::DATA_W-1:0]      ovr_next [ppmd_pkg::CHANNELS];
    logic                             ready_flag_reg, ready_flag_next;

    // result stage
    logic                             out_valid_reg;
    logic [ppmd_pkg::VALUE_W-1:0]     value_reg, value_next;
    logic                             frame_ready_reg;
    logic                             ovr_active_reg, ovr_active_next;

    // per-word working signals
    logic [ppmd_pkg::DATA_W-1:0]      delta;
    logic [ppmd_pkg::DATA_W-1:0]      width;
    logic                             ch_ok;
    logic [ppmd_pkg::IDX_W-1:0]       ch_idx;
    ppmd_pkg::rd_res_t                rd_res;

    // result register frees up when empty or being taken
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;

    assign out_valid       = out_valid_reg;
    assign channel_value   = value_reg;
    assign frame_ready     = frame_ready_reg;
    assign override_active = ovr_active_reg;

    // config write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_pulse_us   <= ppmd_pkg::MIN_PULSE_RESET;
            cfg_reg.max_pulse_us   <= ppmd_pkg::MAX_PULSE_RESET;
            cfg_reg.sync_threshold <= ppmd_pkg::SYNC_RESET;
            cfg_reg.timer_top      <= ppmd_pkg::TIMER_TOP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (ppmd_pkg::cfg_idx_t'(cfg_index))
                ppmd_pkg::REG_MIN_PULSE: cfg_reg.min_pulse_us   <= cfg_data;
                ppmd_pkg::REG_MAX_PULSE: cfg_reg.max_pulse_us   <= cfg_data;
                ppmd_pkg::REG_SYNC:      cfg_reg.sync_threshold <= cfg_data;
                ppmd_pkg::REG_TIMER_TOP: cfg_reg.timer_top      <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_kind_reg <= ppmd_pkg::kind_t'(kind);
            s1_cap_reg  <= capture_time;
            s1_ch_reg   <= channel;
            s1_ov_reg   <= override_value;
        end
    end

    // width since last capture, corrected for the timer wrapping at its top
    assign delta = s1_cap_reg - last_capture_reg;
    assign width = (s1_cap_reg < last_capture_reg) ? (delta + cfg_reg.timer_top) : delta;

    assign ch_ok  = {1'b0, s1_ch_reg} < (ppmd_pkg::CH_W + 1)'(ppmd_pkg::CHANNELS);
    assign ch_idx = s1_ch_reg[ppmd_pkg::IDX_W-1:0];

    ppmd_read_path u_read_path (
        .cfg       (cfg_reg),
        .raw_width (raw_reg[ch_idx]),
        .ovr_entry (ovr_reg[ch_idx]),
        .res       (rd_res)
    );

    always_comb
    begin
        last_capture_next = last_capture_reg;
        next_channel_next = next_channel_reg;
        ready_flag_next   = ready_flag_reg;
        value_next        = '0;
        raw_next          = raw_reg;
        ovr_next          = ovr_reg;

        unique case (s1_kind_reg)
            ppmd_pkg::KIND_CAPTURE:
            begin
                last_capture_next = s1_cap_reg;
                if (width > cfg_reg.sync_threshold)
                begin
                    // frame sync gap
                    next_channel_next = '0;
                end
                else if (next_channel_reg < ppmd_pkg::CNT_W'(ppmd_pkg::CHANNELS))
                begin
                    raw_next[next_channel_reg[ppmd_pkg::IDX_W-1:0]] = width;
                    next_channel_next = next_channel_reg + 1'b1;
                    if (next_channel_next >= ppmd_pkg::CNT_W'(ppmd_pkg::CHANNELS))
                    begin
                        ready_flag_next = 1'b1;
                    end
                end
                // excess pulses after a full frame are dropped until sync
            end
            ppmd_pkg::KIND_READ:
            begin
                if (ch_ok)
                begin
                    value_next = rd_res.value;
                    if (rd_res.clear_ready)
                    begin
                        ready_flag_next = 1'b0;
                    end
                end
            end
            ppmd_pkg::KIND_SET:
            begin
                if (ch_ok && s1_ov_reg != ppmd_pkg::NO_CHANGE)
                begin
                    ovr_next[ch_idx] = s1_ov_reg;
                end
                ready_flag_next = 1'b1;
            end
            ppmd_pkg::KIND_CLEAR:
            begin
                for (int i = 0; i < ppmd_pkg::CHANNELS; i++)
                begin
                    ovr_next[i] = '0;
                end
            end
            default: ;
        endcase
    end

    // any override still set after this word
    always_comb
    begin
        ovr_active_next = 1'b0;
        for (int i = 0; i < ppmd_pkg::CHANNELS; i++)
        begin
            ovr_active_next = ovr_active_next | (ovr_next[i] != '0);
        end
    end

    // decoder state, updated as a word leaves the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_capture_reg <= '0;
            next_channel_reg <= '0;
            ready_flag_reg   <= 1'b0;
            for (int i = 0; i < ppmd_pkg::CHANNELS; i++)
            begin
                raw_reg[i] <= ppmd_pkg::RAW_RESET;
                ovr_reg[i] <= '0;
            end
        end
        else if (s1_fire)
        begin
            last_capture_reg <= last_capture_next;
            next_channel_reg <= next_channel_next;
            ready_flag_reg   <= ready_flag_next;
            raw_reg          <= raw_next;
            ovr_reg          <= ovr_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            value_reg       <= value_next;
            frame_ready_reg <= ready_flag_next;
            ovr_active_reg  <= ovr_active_next;
        end
    end

    // channel counter never runs past a full frame
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        next_channel_reg <= ppmd_pkg::CNT_W'(ppmd_pkg::CHANNELS))
        else $error("channel counter out of range");

    // stalling the input implies both stages are full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled with a free stage");

    // reported flag tracks the state it came from
    a_flag_match: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> (frame_ready == ready_flag_reg))
        else $error("frame_ready differs from held flag");

    // a clear leaves no override behind
    a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_kind_reg == ppmd_pkg::KIND_CLEAR) |=> !override_active)
        else $error("override still active after clear");

    // words other than reads return zero
    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_kind_reg != ppmd_pkg::KIND_READ) |=> (channel_value == '0))
        else $error("non-read word returned a value");

endmodule

// ===== test/ppm_decoder_checker.sv =====
`timescale 1ns / 1ps

module ppm_decoder_checker
    import ppmd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [1:0]           kind,
    input  logic [DATA_W-1:0]    capture_time,
    input  logic [CH_W-1:0]      channel,
    input  logic [DATA_W-1:0]    override_value,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [VALUE_W-1:0]   channel_value,
    input  logic                 frame_ready,
    input  logic                 override_active,
    output int                   mismatches,
    output int                   words_in_flight
);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               ready;
        logic               active;
    } decoded_t;

    decoded_t          decoded_q[$];
    cfg_t              cfg;
    logic [DATA_W-1:0] last_stamp;
    logic [CNT_W-1:0]  slot;
    logic [DATA_W-1:0] raw_store [CHANNELS];
    logic              ready_bit;
    logic [DATA_W-1:0] ovr [CHANNELS];
    int                fails = 0;

    function automatic decoded_t decode_item(input kind_t k, input logic [DATA_W-1:0] cap,
                                             input logic [CH_W-1:0] ch,
                                             input logic [DATA_W-1:0] ov);
        logic [DATA_W:0]   span;
        logic [DATA_W-1:0] width;
        logic [DATA_W-1:0] pulse;
        decoded_t          res;
        res = '0;
        case (k)
            KIND_CAPTURE:
            begin
                // wrap at timer top, kept modulo 2^16
                if (cap < last_stamp)
                    span = {1'b0, cap} + {1'b0, cfg.timer_top} - {1'b0, last_stamp};
                else
                    span = {1'b0, cap} - {1'b0, last_stamp};
                width = span[DATA_W-1:0];
                if (width > cfg.sync_threshold)
                    slot = '0;
                else if (slot < CHANNELS)
                begin
                    raw_store[slot[IDX_W-1:0]] = width;
                    slot = slot + 1'b1;
                    if (slot >= CHANNELS)
                        ready_bit = 1'b1;
                end
                last_stamp = cap;
            end
            KIND_READ:
            begin
                if (int'(ch) < CHANNELS)
                begin
                    if (ovr[ch] != '0)
                        res.value = ovr[ch][DATA_W-1] ? '0 : ovr[ch][VALUE_W-1:0];
                    else
                    begin
                        pulse = {1'b0, raw_store[ch][DATA_W-1:1]};
                        if (pulse < cfg.min_pulse_us)
                            pulse = cfg.min_pulse_us;
                        else if (pulse > cfg.max_pulse_us)
                            pulse = cfg.max_pulse_us;
                        ready_bit = 1'b0;
                        res.value = (pulse > {1'b0, VALUE_MAX}) ? VALUE_MAX
                                                                : pulse[VALUE_W-1:0];
                    end
                end
            end
            KIND_SET:
            begin
                if (int'(ch) < CHANNELS && ov != NO_CHANGE)
                    ovr[ch] = ov;
                ready_bit = 1'b1;
            end
            default:
            begin
                foreach (ovr[j])
                    ovr[j] = '0;
            end
        endcase
        res.ready  = ready_bit;
        res.active = 1'b0;
        foreach (ovr[j])
            if (ovr[j] != '0)
                res.active = 1'b1;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        decoded_t want;
        if (!rst_n)
        begin
            cfg        = '{MIN_PULSE_RESET, MAX_PULSE_RESET, SYNC_RESET, TIMER_TOP_RESET};
            last_stamp = '0;
            slot       = '0;
            ready_bit  = 1'b0;
            foreach (raw_store[j])
                raw_store[j] = RAW_RESET;
            foreach (ovr[j])
                ovr[j] = '0;
            decoded_q.delete();
            words_in_flight <= 0;
            mismatches      <= fails;
        end
        else
        begin
            // results first: a word taken at this edge cannot have left yet
            if (out_valid && out_ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    fails++;
                    $display("%0t: unexpected result: value %0d ready %0b active %0b",
                             $time, channel_value, frame_ready, override_active);
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (channel_value !== want.value)
                    begin
                        fails++;
                        $display("%0t: channel_value expected %0d actual %0d",
                                 $time, want.value, channel_value);
                    end
                    if (frame_ready !== want.ready)
                    begin
                        fails++;
                        $display("%0t: frame_ready expected %0b actual %0b",
                                 $time, want.ready, frame_ready);
                    end
                    if (override_active !== want.active)
                    begin
                        fails++;
                        $display("%0t: override_active expected %0b actual %0b",
                                 $time, want.active, override_active);
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    REG_MIN_PULSE: cfg.min_pulse_us   = cfg_data;
                    REG_MAX_PULSE: cfg.max_pulse_us   = cfg_data;
                    REG_SYNC:      cfg.sync_threshold = cfg_data;
                    REG_TIMER_TOP: cfg.timer_top      = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                decoded_q.push_back(decode_item(kind_t'(kind), capture_time, channel,
                                                override_value));
            words_in_flight <= decoded_q.size();
            mismatches      <= fails;
        end
    end

endmodule

// ===== test/tb_ppm_radio_channel_decoder_core.sv =====
`timescale 1ns / 1ps

module tb_ppm_radio_channel_decoder_core;
    import ppmd_pkg::*;

    localparam int RANDOM_WORDS = 1100;
    localparam int PHASES       = 6;
    localparam int CYCLE_LIMIT  = 600000;
    // pipeline is two stages deep, extra idle cycles follow the last result
    localparam int DRAIN_CYCLES = 8;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_we;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [DATA_W-1:0]           cfg_data;
    logic                        in_valid;
    logic                        in_ready;
    logic [1:0]                  kind;
    logic [DATA_W-1:0]           capture_time;
    logic [CH_W-1:0]             channel;
    logic signed [DATA_W-1:0]    override_value;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic [VALUE_W-1:0]          channel_value;
    logic                        frame_ready;
    logic                        override_active;

    int mismatches;
    int words_in_flight;
    int cycles     = 0;
    int tx_calm    = 0;
    int rx_calm    = 0;
    int stall_left = 0;

    // running capture timestamp as the sender sees it
    logic [DATA_W-1:0] stamp;
    int                frame_pos;

    ppm_radio_channel_decoder_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .capture_time    (capture_time),
        .channel         (channel),
        .override_value  (override_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .channel_value   (channel_value),
        .frame_ready     (frame_ready),
        .override_active (override_active)
    );

    ppm_decoder_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .capture_time    (capture_time),
        .channel         (channel),
        .override_value  (override_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .channel_value   (channel_value),
        .frame_ready     (frame_ready),
        .override_active (override_active),
        .mismatches      (mismatches),
        .words_in_flight (words_in_flight)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // idle length: mostly none or short, now and then long, with calm stretches
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            calm = $urandom_range(30, 150);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side back-pressure
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            stall_left = pick_gap(rx_calm);
            out_ready <= (stall_left == 0);
            if (stall_left > 0)
                stall_left = stall_left - 1;
        end
    end

    // present one word, hold it until taken, then maybe idle
    task automatic send_word(input kind_t k, input logic [DATA_W-1:0] t,
                             input logic [CH_W-1:0] ch, input logic [DATA_W-1:0] ov);
        int gap;
        kind           <= k;
        capture_time   <= t;
        channel        <= ch;
        override_value <= ov;
        in_valid       <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        gap = pick_gap(tx_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop sending and wait for every outstanding result word
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (words_in_flight != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // all four registers, one per edge, only once the block is quiet
    task automatic program_regs(input cfg_t c);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_MIN_PULSE;
        cfg_data  <= c.min_pulse_us;
        @(posedge clk);
        cfg_index <= REG_MAX_PULSE;
        cfg_data  <= c.max_pulse_us;
        @(posedge clk);
        cfg_index <= REG_SYNC;
        cfg_data  <= c.sync_threshold;
        @(posedge clk);
        cfg_index <= REG_TIMER_TOP;
        cfg_data  <= c.timer_top;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        cfg_t              setting;
        logic [DATA_W-1:0] t;
        logic [DATA_W-1:0] ov;
        int                r;
        int                q;
        int                w;
        int                hi;
        int                lo;

        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= REG_MIN_PULSE;
        cfg_data       <= '0;
        in_valid       <= 1'b0;
        kind           <= KIND_CAPTURE;
        capture_time   <= '0;
        channel        <= '0;
        override_value <= '0;
        stamp     = '0;
        frame_pos = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset settings
        // read before any capture: reset width halved, inside the clamp
        send_word(KIND_READ, 16'd0, 3'd0, 16'd0);
        // short width, then a sync gap
        send_word(KIND_CAPTURE, 16'd100, 3'd1, 16'd0);
        send_word(KIND_CAPTURE, 16'd9000, 3'd2, 16'd0);
        // width exactly on the threshold is still a channel
        send_word(KIND_CAPTURE, 16'd17000, 3'd3, 16'd0);
        // timer wrap, long enough to count as sync
        send_word(KIND_CAPTURE, 16'd5, 3'd4, 16'd0);
        // full frame plus one excess pulse that is dropped
        stamp = 16'd5;
        for (int n = 0; n <= CHANNELS; n++)
        begin
            stamp = stamp + 16'd3000;
            send_word(KIND_CAPTURE, stamp, CH_W'(n), 16'hFFFF);
        end
        // read clears frame-ready
        send_word(KIND_READ, 16'hFFFF, 3'd3, 16'h8000);
        // largest override and its read-back
        send_word(KIND_SET, 16'd0, 3'd2, 16'h7FFF);
        send_word(KIND_READ, 16'd0, 3'd2, 16'd0);
        // no-change code keeps the entry, a negative entry reads as zero
        send_word(KIND_SET, 16'd0, 3'd2, NO_CHANGE);
        send_word(KIND_SET, 16'd0, 3'd5, 16'hFFFE);
        send_word(KIND_READ, 16'd0, 3'd5, 16'd0);
        send_word(KIND_READ, 16'd0, 3'd2, 16'd0);
        // zero removes one override, clear drops the rest
        send_word(KIND_SET, 16'd0, 3'd2, 16'd0);
        send_word(KIND_CLEAR, 16'hFFFF, 3'd7, 16'hFFFF);

        // random part over several register settings
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                1:       setting = '{16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF};
                // min above max, any nonzero width counts as sync, timer top of one
                2:       setting = '{16'hFFFF, 16'd0, 16'd0, 16'd1};
                3:       setting = '{16'd1500, 16'd1000, 16'd3000, 16'd5000};
                4:       setting = '{DATA_W'($urandom), DATA_W'($urandom),
                                     DATA_W'($urandom_range(2000, 20000)),
                                     DATA_W'($urandom_range(1, 65535))};
                default: setting = '{MIN_PULSE_RESET, MAX_PULSE_RESET, SYNC_RESET,
                                     TIMER_TOP_RESET};
            endcase
            program_regs(setting);
            hi = (setting.sync_threshold < 4400) ? setting.sync_threshold : 4400;
            lo = (hi < 1800) ? hi : 1800;

            for (int n = 0; n < RANDOM_WORDS / PHASES; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                begin
                    if ($urandom_range(0, 9) == 0)
                        t = DATA_W'($urandom);
                    else
                    begin
                        // frames: a sync gap, the channel pulses, sometimes extras
                        if (frame_pos == 0)
                        begin
                            w = int'(setting.sync_threshold) + 1 + $urandom_range(0, 3000);
                            if (w > 65535)
                                w = 65535;
                            frame_pos = 1;
                        end
                        else
                        begin
                            if ($urandom_range(0, 6) == 0)
                                w = $urandom_range(0, 65535);
                            else
                                w = $urandom_range(lo, hi);
                            if ($urandom_range(0, 19) == 0)
                                frame_pos = 0;
                            else if (frame_pos > CHANNELS && $urandom_range(0, 3) != 0)
                                frame_pos = 0;
                            else
                                frame_pos++;
                        end
                        t = DATA_W'((int'(stamp) + w) % int'(setting.timer_top));
                    end
                    stamp = t;
                    send_word(KIND_CAPTURE, t, CH_W'($urandom), DATA_W'($urandom));
                end
                else if (r < 80)
                    send_word(KIND_READ, DATA_W'($urandom), CH_W'($urandom),
                              DATA_W'($urandom));
                else if (r < 94)
                begin
                    q = $urandom_range(0, 99);
                    if (q < 45)
                        ov = '0;
                    else if (q < 60)
                        ov = NO_CHANGE;
                    else if (q < 85)
                        ov = DATA_W'($urandom_range(1, 32767));
                    else if (q < 95)
                        ov = {1'b1, 15'($urandom)};
                    else
                        ov = 16'h7FFF;
                    send_word(KIND_SET, DATA_W'($urandom), CH_W'($urandom), ov);
                end
                else
                    send_word(KIND_CLEAR, DATA_W'($urandom), CH_W'($urandom),
                              DATA_W'($urandom));

                // now and then let the pipeline run dry
                if ($urandom_range(0, 299) == 0)
                    settle();
            end
        end

        settle();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
